>>> rtl/vkts_pkg.sv
// shared types and codes for the keyframe track sampler
package vkts_pkg;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;

  localparam logic [1:0] ST_SAMPLED = 2'd0;
  localparam logic [1:0] ST_STORED  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  localparam int CFG_DEF_X = 0;
  localparam int CFG_DEF_Y = 1;
  localparam int CFG_DEF_Z = 2;

  // key entry packing: time, x, y, z
  localparam int KEY_W = 128;

  typedef enum logic [1:0] {
    K_CLEAR,
    K_APPEND,
    K_SAMPLE
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] time_value;
    logic [31:0] value_x;
    logic [31:0] value_y;
    logic [31:0] value_z;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

>>> rtl/vector_keyframe_track_sampler_unit.sv
// top level of the keyframe track sampler with linear interpolation
// Commands enter through a two-entry queue; busy is high while it is full.
// Each command gives one result, shown for one cycle with out_valid, which
// the receiver must take as it comes. The result of a clear or append is
// registered in the cycle after it leaves the queue. A sample walks the
// stored keys through the key memory's single read port; unless it lies at
// or past the last key, it runs a bit-serial divide (when the fraction is
// strictly between zero and one) and three passes of one shared multiplier.
// Writes to default_x/y/z must go in while idle; the block does not check.
module vector_keyframe_track_sampler_unit #(
  parameter int MAX_KEYS      = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_time_value,
  input  logic [31:0] in_value_x,
  input  logic [31:0] in_value_y,
  input  logic [31:0] in_value_z,
  output logic        out_valid,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0]     def_x_r, def_y_r, def_z_r;
  vkts_pkg::head_t head;
  logic            pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_x_r <= '0;
      def_y_r <= '0;
      def_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        2'(vkts_pkg::CFG_DEF_X): def_x_r <= cfg_data;
        2'(vkts_pkg::CFG_DEF_Y): def_y_r <= cfg_data;
        2'(vkts_pkg::CFG_DEF_Z): def_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  vkts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .command    (in_command),
    .time_value (in_time_value),
    .value_x    (in_value_x),
    .value_y    (in_value_y),
    .value_z    (in_value_z),
    .busy       (busy),
    .pop        (pop),
    .head       (head)
  );

  vkts_back #(
    .MAX_KEYS      (MAX_KEYS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .def_x      (def_x_r),
    .def_y      (def_y_r),
    .def_z      (def_z_r),
    .out_valid  (out_valid),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .out_status (out_status)
  );

endmodule

>>> rtl/vkts_ram.sv
// generic single write, single read ram with registered read
module vkts_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/vkts_front.sv
// command intake: decode and two-entry queue towards the execution side
module vkts_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           command,
  input  logic [31:0]          time_value,
  input  logic [31:0]          value_x,
  input  logic [31:0]          value_y,
  input  logic [31:0]          value_z,
  output logic                 busy,
  input  logic                 pop,
  output vkts_pkg::head_t      head
);

  vkts_pkg::item_t q_r [2];
  logic            wptr_r, rptr_r;
  logic [1:0]      cnt_r;
  vkts_pkg::item_t in_item;
  logic            push, do_pop;

  always_comb begin
    in_item.time_value = time_value;
    in_item.value_x    = value_x;
    in_item.value_y    = value_y;
    in_item.value_z    = value_z;
    // unused code 3 behaves as a sample
    if (command[1]) begin
      in_item.kind = vkts_pkg::K_SAMPLE;
    end else if (command == vkts_pkg::CMD_APPEND) begin
      in_item.kind = vkts_pkg::K_APPEND;
    end else begin
      in_item.kind = vkts_pkg::K_CLEAR;
    end
  end

  assign busy   = (cnt_r == 2'd2);
  assign push   = start && !busy;
  assign do_pop = pop && (cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= in_item;
    end
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (do_pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(do_pop);
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rptr_r];

endmodule

>>> rtl/vkts_back.sv
// execution side: key store, scan, serial divide and interpolation
module vkts_back #(
  parameter int MAX_KEYS      = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  vkts_pkg::head_t head,
  output logic            pop,
  input  logic [31:0]     def_x,
  input  logic [31:0]     def_y,
  input  logic [31:0]     def_z,
  output logic            out_valid,
  output logic [31:0]     out_x,
  output logic [31:0]     out_y,
  output logic [31:0]     out_z,
  output logic [1:0]      out_status
);

  localparam int AW  = $clog2(MAX_KEYS);
  localparam int CW  = $clog2(MAX_KEYS + 1);
  localparam int FB  = FRACTION_BITS;
  localparam int DCW = $clog2(FB + 1);
  localparam int PW  = 34 + FB;
  localparam int KW  = vkts_pkg::KEY_W;

  typedef enum logic [2:0] {
    S_IDLE, S_ISSUE, S_CHECK, S_FRAC, S_DIV, S_MUL, S_ACC
  } state_t;

  state_t               state_r;
  logic [CW-1:0]        count_r;
  logic [AW-1:0]        idx_r;
  logic [31:0]          t_r;
  logic [KW-1:0]        prev_r, cur_r;
  logic [32:0]          rem_r;
  logic [31:0]          den_r;
  logic [FB-1:0]        q_r;
  logic [FB:0]          f_r;
  logic [DCW-1:0]       dcnt_r;
  logic [1:0]           comp_r;
  logic signed [PW-1:0] prod_r;
  logic [31:0]          res_x_r, res_y_r;
  logic                 out_valid_r;
  logic [31:0]          out_x_r, out_y_r, out_z_r;
  logic [1:0]           out_status_r;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [KW-1:0] ram_wdata, rdata;
  logic          full;

  vkts_ram #(.WIDTH(KW), .DEPTH(MAX_KEYS)) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  assign full      = (count_r == CW'(MAX_KEYS));
  assign pop       = (state_r == S_IDLE) && head.valid;
  assign ram_we    = pop && (head.item.kind == vkts_pkg::K_APPEND) && !full;
  assign ram_wdata = {head.item.time_value, head.item.value_x,
                      head.item.value_y, head.item.value_z};
  assign ram_raddr = idx_r;

  // fraction operands
  logic signed [32:0] num, den;
  logic [31:0]        an, ad;
  always_comb begin
    num = $signed({1'b0, t_r}) - $signed({1'b0, prev_r[127:96]});
    den = $signed({1'b0, cur_r[127:96]}) - $signed({1'b0, prev_r[127:96]});
    an  = num[32] ? 32'(-num) : num[31:0];
    ad  = den[32] ? 32'(-den) : den[31:0];
  end

  // divider step
  logic [32:0] r2;
  logic        qbit;
  assign r2   = {rem_r[31:0], 1'b0};
  assign qbit = (r2 >= {1'b0, den_r});

  // component select for the shared multiplier
  logic [31:0]          ca, cb;
  logic signed [32:0]   dd;
  logic signed [PW-1:0] de, fe, prod_sh;
  logic [31:0]          sum;
  always_comb begin
    case (comp_r)
      2'd0:    begin ca = prev_r[95:64]; cb = cur_r[95:64]; end
      2'd1:    begin ca = prev_r[63:32]; cb = cur_r[63:32]; end
      default: begin ca = prev_r[31:0];  cb = cur_r[31:0];  end
    endcase
    dd      = $signed({cb[31], cb}) - $signed({ca[31], ca});
    de      = PW'(dd);
    fe      = $signed(PW'(f_r));
    // arithmetic shift gives floor division
    prod_sh = prod_r >>> FB;
    sum     = ca + prod_sh[31:0];
  end

  always_ff @(posedge clk) begin
    out_valid_r <= 1'b0;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (head.valid) begin
            out_x_r <= '0;
            out_y_r <= '0;
            out_z_r <= '0;
            t_r     <= head.item.time_value;
            case (head.item.kind)
              vkts_pkg::K_CLEAR: begin
                count_r      <= '0;
                out_status_r <= vkts_pkg::ST_CLEARED;
                out_valid_r  <= 1'b1;
              end
              vkts_pkg::K_APPEND: begin
                if (full) begin
                  out_status_r <= vkts_pkg::ST_FULL;
                end else begin
                  count_r      <= count_r + CW'(1);
                  out_status_r <= vkts_pkg::ST_STORED;
                end
                out_valid_r <= 1'b1;
              end
              default: begin
                out_status_r <= vkts_pkg::ST_SAMPLED;
                if (count_r == '0) begin
                  out_x_r     <= def_x;
                  out_y_r     <= def_y;
                  out_z_r     <= def_z;
                  out_valid_r <= 1'b1;
                end else begin
                  idx_r   <= '0;
                  state_r <= S_ISSUE;
                end
              end
            endcase
          end
        end
        S_ISSUE: begin
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (idx_r != '0 && t_r < rdata[127:96]) begin
            cur_r   <= rdata;
            state_r <= S_FRAC;
          end else if (CW'(idx_r) == count_r - CW'(1)) begin
            // past the last key
            out_x_r     <= rdata[95:64];
            out_y_r     <= rdata[63:32];
            out_z_r     <= rdata[31:0];
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            prev_r  <= rdata;
            idx_r   <= idx_r + AW'(1);
            state_r <= S_ISSUE;
          end
        end
        S_FRAC: begin
          comp_r <= 2'd0;
          if (num == '0 || den == '0 || num[32] != den[32]) begin
            f_r     <= '0;
            state_r <= S_MUL;
          end else if (an >= ad) begin
            f_r     <= (FB + 1)'(1) << FB;
            state_r <= S_MUL;
          end else begin
            rem_r   <= {1'b0, an};
            den_r   <= ad;
            dcnt_r  <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r  <= qbit ? (r2 - {1'b0, den_r}) : r2;
          q_r    <= {q_r[FB-2:0], qbit};
          dcnt_r <= dcnt_r + DCW'(1);
          if (dcnt_r == DCW'(FB - 1)) begin
            f_r     <= {1'b0, q_r[FB-2:0], qbit};
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= de * fe;
          state_r <= S_ACC;
        end
        S_ACC: begin
          comp_r <= comp_r + 2'd1;
          case (comp_r)
            2'd0: begin
              res_x_r <= sum;
              state_r <= S_MUL;
            end
            2'd1: begin
              res_y_r <= sum;
              state_r <= S_MUL;
            end
            default: begin
              out_x_r     <= res_x_r;
              out_y_r     <= res_y_r;
              out_z_r     <= sum;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          endcase
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_z      = out_z_r;
  assign out_status = out_status_r;

endmodule

>>> verif/vector_keyframe_track_sampler_unit_tb.sv
// testbench for the keyframe track sampler: directed table, a fill past capacity, then random tracks
`timescale 1ns / 1ps

module vector_keyframe_track_sampler_unit_tb;

  localparam logic [1:0] CMD_SAMPLE = 2'd2;
  localparam logic [1:0] CMD_ALIAS  = 2'd3;  // high bit set, behaves as a sample
  localparam logic [1:0] CFG_SPARE  = 2'd3;  // no register behind this index
  localparam logic [1:0] CFG_X = 2'(vkts_pkg::CFG_DEF_X);
  localparam logic [1:0] CFG_Y = 2'(vkts_pkg::CFG_DEF_Y);
  localparam logic [1:0] CFG_Z = 2'(vkts_pkg::CFG_DEF_Z);
  localparam int NKEYS = 16;
  localparam int FBITS = 16;
  localparam longint FONE = 64'd1 << FBITS;
  localparam int STALL_LIMIT = 2000;
  localparam int NDIR = 15;

  typedef struct {
    logic [31:0] x, y, z;
    logic [1:0]  st;
  } sample_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] t, x, y, z;
    bit          known;
    sample_t     res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = '0;
  logic [31:0] in_time_value = '0;
  logic [31:0] in_value_x = '0;
  logic [31:0] in_value_y = '0;
  logic [31:0] in_value_z = '0;
  logic        out_valid;
  logic [31:0] out_x, out_y, out_z;
  logic [1:0]  out_status;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor state
  logic [31:0] def_x, def_y, def_z;
  int          nkeys;
  logic [31:0] kt[NKEYS], kx[NKEYS], ky[NKEYS], kz[NKEYS];

  sample_t pending[$];
  int      errors = 0;
  int      items = 0;
  int      idle_pct = 0;
  int      quiet = 0;
  row_t    rows[NDIR];

  vector_keyframe_track_sampler_unit dut (.*);

  always #2 clk = ~clk;

  function automatic longint frac_of(logic [31:0] t, logic [31:0] t0, logic [31:0] t1);
    longint num, den, an, ad;
    num = longint'({32'b0, t}) - longint'({32'b0, t0});
    den = longint'({32'b0, t1}) - longint'({32'b0, t0});
    if (num == 0 || den == 0 || ((num < 0) != (den < 0))) return 0;
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    if (an >= ad) return FONE;
    return (an << FBITS) / ad;
  endfunction

  function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, longint f);
    longint sa, prod;
    sa = longint'(signed'(a));
    prod = (longint'(signed'(b)) - sa) * f;
    // arithmetic shift floors toward minus infinity
    return 32'(sa + (prod >>> FBITS));
  endfunction

  function automatic sample_t track_next(logic [1:0] cmd, logic [31:0] t,
                                         logic [31:0] x, logic [31:0] y, logic [31:0] z);
    sample_t r;
    longint  f;
    r = '{0, 0, 0, vkts_pkg::ST_SAMPLED};
    if (cmd == vkts_pkg::CMD_CLEAR) begin
      nkeys = 0;
      r.st = vkts_pkg::ST_CLEARED;
    end else if (cmd == vkts_pkg::CMD_APPEND) begin
      if (nkeys < NKEYS) begin
        kt[nkeys] = t; kx[nkeys] = x; ky[nkeys] = y; kz[nkeys] = z;
        nkeys++;
        r.st = vkts_pkg::ST_STORED;
      end else begin
        r.st = vkts_pkg::ST_FULL;
      end
    end else if (nkeys == 0) begin
      r.x = def_x; r.y = def_y; r.z = def_z;
    end else begin
      r.x = kx[nkeys-1]; r.y = ky[nkeys-1]; r.z = kz[nkeys-1];
      for (int i = 1; i < nkeys; i++) begin
        if (t < kt[i]) begin
          f = frac_of(t, kt[i-1], kt[i]);
          r.x = blend(kx[i-1], kx[i], f);
          r.y = blend(ky[i-1], ky[i], f);
          r.z = blend(kz[i-1], kz[i], f);
          break;
        end
      end
    end
    return r;
  endfunction

  task automatic send(logic [1:0] cmd, logic [31:0] t,
                      logic [31:0] x, logic [31:0] y, logic [31:0] z,
                      bit known = 0, sample_t res = '{0, 0, 0, 0});
    sample_t r;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd; in_time_value <= t;
    in_value_x <= x; in_value_y <= y; in_value_z <= z;
    do @(posedge clk); while (busy);
    r = track_next(cmd, t, x, y, z);
    pending.push_back(known ? res : r);
    items++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_X: def_x = val;
      CFG_Y: def_y = val;
      CFG_Z: def_z = val;
      default: ;
    endcase
  endtask

  task automatic set_defaults(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    drain();
    write_reg(CFG_X, x);
    write_reg(CFG_Y, y);
    write_reg(CFG_Z, z);
    write_reg(CFG_SPARE, $urandom);
  endtask

  // clear, a run of keys mostly in time order, then samples mostly over the span, sometimes a last random command
  task automatic random_track();
    int n, m;
    logic [31:0] t, t0;
    send(vkts_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 5);
    t = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h000f_ffff);
    t0 = t;
    for (int k = 0; k < n; k++) begin
      send(vkts_pkg::CMD_APPEND, t, $urandom, $urandom, $urandom);
      t = ($urandom_range(0, 15) == 0) ? t : t + $urandom_range(1, 32'h0004_0000);
    end
    m = $urandom_range(1, 6);
    for (int k = 0; k < m; k++) begin
      if ($urandom_range(0, 7) == 0)
        send($urandom_range(0, 1) ? CMD_ALIAS : CMD_SAMPLE, $urandom, $urandom,
             $urandom, $urandom);
      else
        send(CMD_SAMPLE, $urandom_range(t0, t + 32'h0001_0000), $urandom, $urandom,
             $urandom);
    end
    if ($urandom_range(0, 3) == 0)
      send(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
  endtask

  always @(posedge clk) begin
    sample_t e;
    if (rst_n && out_valid) begin
      if (pending.size() == 0) begin
        $display("%0t unexpected item: x %h y %h z %h status %0d",
                 $time, out_x, out_y, out_z, out_status);
        errors++;
      end else begin
        e = pending.pop_front();
        if (out_x !== e.x) begin
          $display("%0t out_x expected %h actual %h", $time, e.x, out_x); errors++;
        end
        if (out_y !== e.y) begin
          $display("%0t out_y expected %h actual %h", $time, e.y, out_y); errors++;
        end
        if (out_z !== e.z) begin
          $display("%0t out_z expected %h actual %h", $time, e.z, out_z); errors++;
        end
        if (out_status !== e.st) begin
          $display("%0t out_status expected %0d actual %0d", $time, e.st, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    def_x = '0; def_y = '0; def_z = '0;
    nkeys = 0;
    rows[0]  = '{CMD_SAMPLE, 32'h0000_1234, 0, 0, 0, 1, '{0, 0, 0, vkts_pkg::ST_SAMPLED}};
    rows[1]  = '{vkts_pkg::CMD_APPEND, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 1,
                 '{0, 0, 0, vkts_pkg::ST_STORED}};
    rows[2]  = '{CMD_SAMPLE, 32'h0000_0000, 0, 0, 0, 1,
                 '{32'h7fff_ffff, 32'h8000_0000, 0, vkts_pkg::ST_SAMPLED}};
    rows[3]  = '{vkts_pkg::CMD_APPEND, 32'h0003_0000, 32'h8000_0000, 32'h7fff_ffff,
                 32'hffff_ffff, 1, '{0, 0, 0, vkts_pkg::ST_STORED}};
    rows[4]  = '{CMD_SAMPLE, 32'h0002_0000, 0, 0, 0, 0, '{0, 0, 0, 0}};
    rows[5]  = '{CMD_SAMPLE, 32'hffff_ffff, 0, 0, 0, 1,
                 '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, vkts_pkg::ST_SAMPLED}};
    // before the first key: fraction zero gives key 0
    rows[6]  = '{CMD_SAMPLE, 32'h0000_0000, 0, 0, 0, 1,
                 '{32'h7fff_ffff, 32'h8000_0000, 0, vkts_pkg::ST_SAMPLED}};
    // out of time order
    rows[7]  = '{vkts_pkg::CMD_APPEND, 32'h0002_0000, 32'h0001_0000, 32'hfff0_0000,
                 32'h1234_5678, 1, '{0, 0, 0, vkts_pkg::ST_STORED}};
    rows[8]  = '{CMD_SAMPLE, 32'h0002_8000, 0, 0, 0, 0, '{0, 0, 0, 0}};
    rows[9]  = '{CMD_SAMPLE, 32'h0001_8000, 0, 0, 0, 0, '{0, 0, 0, 0}};
    rows[10] = '{CMD_ALIAS, 32'h0000_c000, 32'hffff_ffff, 0, 0, 0, '{0, 0, 0, 0}};
    // zero span against the previous key
    rows[11] = '{vkts_pkg::CMD_APPEND, 32'h0002_0000, 0, 32'h0000_0001, 32'h8000_0000, 1,
                 '{0, 0, 0, vkts_pkg::ST_STORED}};
    rows[12] = '{CMD_SAMPLE, 32'h0002_0000, 0, 0, 0, 0, '{0, 0, 0, 0}};
    rows[13] = '{vkts_pkg::CMD_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                 32'hffff_ffff, 1, '{0, 0, 0, vkts_pkg::ST_CLEARED}};
    rows[14] = '{CMD_SAMPLE, 32'h0000_0001, 0, 0, 0, 1, '{0, 0, 0, vkts_pkg::ST_SAMPLED}};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 18;
    foreach (rows[i])
      send(rows[i].cmd, rows[i].t, rows[i].x, rows[i].y, rows[i].z,
           rows[i].known, rows[i].res);
    // fill past capacity: the last append is dropped
    for (int k = 0; k <= NKEYS; k++)
      send(vkts_pkg::CMD_APPEND, 32'h0001_0000 * k, $urandom, $urandom, $urandom);
    send(CMD_SAMPLE, 32'hffff_ffff, 0, 0, 0);
    send(CMD_SAMPLE, 32'h0007_8000, 0, 0, 0);

    set_defaults(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
    while (items < 250) random_track();

    idle_pct = 69;
    set_defaults(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    while (items < 480) random_track();

    idle_pct = 0;
    set_defaults($urandom, $urandom, $urandom);
    while (items < 720) random_track();

    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> files.f
rtl/vkts_pkg.sv
rtl/vkts_ram.sv
rtl/vkts_front.sv
rtl/vkts_back.sv
rtl/vector_keyframe_track_sampler_unit.sv
verif/vector_keyframe_track_sampler_unit_tb.sv
